// ----- rtl/ich_pkg.sv -----
// Shared types and constants for the ichimoku cloud lines unit.
package ich_pkg;

  // Field widths of the bar and result items
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned TWICE_W = PRICE_W + 1;
  localparam int unsigned QUAD_W  = PRICE_W + 2;
  localparam int unsigned LEN_W   = 7;

  // Configuration port geometry
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Register indexes (word address)
  localparam logic [1:0] REG_CONVERSION_LEN = 2'd0;
  localparam logic [1:0] REG_BASE_LEN       = 2'd1;
  localparam logic [1:0] REG_SPAN_B_LEN     = 2'd2;

  // Reset values of the window lengths
  localparam logic [LEN_W-1:0] CONVERSION_LEN_RST = 7'd9;
  localparam logic [LEN_W-1:0] BASE_LEN_RST       = 7'd26;
  localparam logic [LEN_W-1:0] SPAN_B_LEN_RST     = 7'd52;

  typedef struct packed {
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
  } in_item_t;

  typedef struct packed {
    logic [TWICE_W-1:0] conversion_twice;
    logic [TWICE_W-1:0] base_twice;
    logic [QUAD_W-1:0]  span_a_quad;
    logic [TWICE_W-1:0] span_b_twice;
    logic               ready_res;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] conversion_len;
    logic [LEN_W-1:0] base_len;
    logic [LEN_W-1:0] span_b_len;
  } cfg_t;

  // Per-cell shift control
  typedef struct packed {
    logic advance;
    logic first;
  } cell_ctrl_t;

endpackage

// ----- rtl/ich_cell.sv -----
// One window cell: running highest high and lowest low over a fixed depth.
module ich_cell (
  input  logic                    clk_i,
  input  ich_pkg::cell_ctrl_t     ctrl_i,
  input  logic [ich_pkg::PRICE_W-1:0] x_hi_i,
  input  logic [ich_pkg::PRICE_W-1:0] x_lo_i,
  input  logic [ich_pkg::PRICE_W-1:0] prev_hi_i,
  input  logic [ich_pkg::PRICE_W-1:0] prev_lo_i,
  output logic [ich_pkg::PRICE_W-1:0] hi_o,
  output logic [ich_pkg::PRICE_W-1:0] lo_o
);
  import ich_pkg::*;

  logic [PRICE_W-1:0] hi_q, hi_d;
  logic [PRICE_W-1:0] lo_q, lo_d;

  // Fold the new bar into the neighbor's window of one bar less
  always_comb begin
    hi_d = x_hi_i;
    lo_d = x_lo_i;
    if (!ctrl_i.first) begin
      if (prev_hi_i > x_hi_i) begin
        hi_d = prev_hi_i;
      end
      if (prev_lo_i < x_lo_i) begin
        lo_d = prev_lo_i;
      end
    end
  end

  // Hold until the next bar transfer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign hi_o = hi_q;
  assign lo_o = lo_q;

endmodule

// ----- rtl/ich_cfg.sv -----
// APB register file holding the three window lengths.
module ich_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ich_pkg::APB_AW-1:0]    paddr,
  input  logic [ich_pkg::APB_DW-1:0]    pwdata,
  output logic [ich_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output ich_pkg::cfg_t                 cfg_o
);
  import ich_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Decode writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_CONVERSION_LEN: cfg_d.conversion_len = pwdata[LEN_W-1:0];
        REG_BASE_LEN:       cfg_d.base_len       = pwdata[LEN_W-1:0];
        REG_SPAN_B_LEN:     cfg_d.span_b_len     = pwdata[LEN_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conversion_len <= CONVERSION_LEN_RST;
      cfg_q.base_len       <= BASE_LEN_RST;
      cfg_q.span_b_len     <= SPAN_B_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_CONVERSION_LEN: prdata = APB_DW'(cfg_q.conversion_len);
      REG_BASE_LEN:       prdata = APB_DW'(cfg_q.base_len);
      REG_SPAN_B_LEN:     prdata = APB_DW'(cfg_q.span_b_len);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/ichimoku_cloud_lines_unit.sv -----
// Top level of the ichimoku cloud lines unit: cell chain, window select and result pipeline.
//
// Takes one price bar per cycle and returns one result per bar after the bar is transferred,
// sustaining one bar per cycle while the result side keeps up. A chain of
// MAX_WINDOW cells holds, in cell k, the highest high and lowest low over the newest k+1 bars;
// on each bar every cell folds the new bar into its neighbor's value, so each window is read
// from the cell at depth len-1 (a length of zero counts as one, a length above MAX_WINDOW
// counts as MAX_WINDOW). Before a window has filled it covers the bars seen so far. The first
// stage selects the three cells and forms the doubled sums, the second adds span A and holds
// the result; either stage can stall while the next bar is taken.
module ichimoku_cloud_lines_unit #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ich_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ich_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ich_pkg::APB_AW-1:0] paddr,
  input  logic [ich_pkg::APB_DW-1:0] pwdata,
  output logic [ich_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import ich_pkg::*;

  localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW);

  cfg_t cfg;

  ich_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake and pipeline control
  logic             in_xfer;
  logic             pend_q, pend_d;
  logic             sa_valid_q, sa_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             sa_load, out_load;
  logic [CNT_W-1:0] bars_q, bars_d;
  cell_ctrl_t       cell_ctrl;

  assign out_load   = sa_valid_q && (!out_valid_q || out_ready_i);
  assign sa_load    = pend_q && (!sa_valid_q || out_load);
  assign in_ready_o = !pend_q || sa_load;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign cell_ctrl.advance = in_xfer;
  assign cell_ctrl.first   = (bars_q == '0);

  // Cell chain
  logic [PRICE_W-1:0] cell_hi [MAX_WINDOW];
  logic [PRICE_W-1:0] cell_lo [MAX_WINDOW];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      ich_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (cell_ctrl),
        .x_hi_i    (in_data_i.high_price),
        .x_lo_i    (in_data_i.low_price),
        .prev_hi_i (in_data_i.high_price),
        .prev_lo_i (in_data_i.low_price),
        .hi_o      (cell_hi[k]),
        .lo_o      (cell_lo[k])
      );
    end else begin : g_body
      ich_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (cell_ctrl),
        .x_hi_i    (in_data_i.high_price),
        .x_lo_i    (in_data_i.low_price),
        .prev_hi_i (cell_hi[k-1]),
        .prev_lo_i (cell_lo[k-1]),
        .hi_o      (cell_hi[k]),
        .lo_o      (cell_lo[k])
      );
    end
  end

  // Count bars, saturating at the chain depth
  always_comb begin
    bars_d = bars_q;
    if (in_xfer && (bars_q < CNT_MAX)) begin
      bars_d = bars_q + CNT_W'(1);
    end
  end

  // Map a window length to the depth of its cell
  function automatic logic [IDX_W-1:0] len_to_idx(input logic [LEN_W-1:0] len);
    logic [IDX_W-1:0] idx;
    if (len == '0) begin
      idx = '0;
    end else if (int'(len) > MAX_WINDOW) begin
      idx = IDX_W'(MAX_WINDOW - 1);
    end else begin
      idx = IDX_W'(len - LEN_W'(1));
    end
    return idx;
  endfunction

  logic [IDX_W-1:0]   conv_idx, base_idx, spanb_idx;
  logic [TWICE_W-1:0] conv_sum, base_sum, spanb_sum;
  logic               ready_flag;

  assign conv_idx  = len_to_idx(cfg.conversion_len);
  assign base_idx  = len_to_idx(cfg.base_len);
  assign spanb_idx = len_to_idx(cfg.span_b_len);

  // Select each window's cell and form the doubled midprice
  assign conv_sum   = TWICE_W'(cell_hi[conv_idx]) + TWICE_W'(cell_lo[conv_idx]);
  assign base_sum   = TWICE_W'(cell_hi[base_idx]) + TWICE_W'(cell_lo[base_idx]);
  assign spanb_sum  = TWICE_W'(cell_hi[spanb_idx]) + TWICE_W'(cell_lo[spanb_idx]);
  assign ready_flag = (CNT_W'(spanb_idx) < bars_q);

  // Stage A: window sums
  logic [TWICE_W-1:0] sa_conv_q, sa_base_q, sa_spanb_q;
  logic               sa_ready_q;

  always_ff @(posedge clk_i) begin
    if (sa_load) begin
      sa_conv_q  <= conv_sum;
      sa_base_q  <= base_sum;
      sa_spanb_q <= spanb_sum;
      sa_ready_q <= ready_flag;
    end
  end

  // Output stage: add span A and hold until taken
  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.conversion_twice <= sa_conv_q;
      out_q.base_twice       <= sa_base_q;
      out_q.span_a_quad      <= QUAD_W'(sa_conv_q) + QUAD_W'(sa_base_q);
      out_q.span_b_twice     <= sa_spanb_q;
      out_q.ready_res        <= sa_ready_q;
    end
  end

  // Advance valid flags
  always_comb begin
    pend_d      = in_xfer ? 1'b1 : (sa_load ? 1'b0 : pend_q);
    sa_valid_d  = sa_load ? 1'b1 : (out_load ? 1'b0 : sa_valid_q);
    out_valid_d = out_load ? 1'b1 : ((out_valid_q && out_ready_i) ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      sa_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bars_q      <= '0;
    end else begin
      pend_q      <= pend_d;
      sa_valid_q  <= sa_valid_d;
      out_valid_q <= out_valid_d;
      bars_q      <= bars_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_pend_after_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> pend_q)
    else $error("bar transfer did not mark the chain pending");

  a_bars_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bars_q <= CNT_MAX)
    else $error("bar count above chain depth");

  a_bars_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (bars_q < CNT_MAX)) |=> (bars_q == $past(bars_q) + CNT_W'(1)))
    else $error("bar count did not advance on transfer");

  a_sa_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sa_valid_q && !out_load) |=> (sa_valid_q && $stable(sa_conv_q)))
    else $error("stage A lost its sums while stalled");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !sa_load) |-> !in_xfer)
    else $error("chain advanced before its sums were sampled");

endmodule

// ----- test/tb.sv -----
// Self-checking bench for the ichimoku cloud lines unit: window sums, warm-up, stalls, APB setup.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ich_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              in_valid_i;
  logic              in_ready_o;
  in_item_t          in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_item_t         out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ichimoku_cloud_lines_unit #(.MAX_WINDOW(DEPTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: bar histories newest first, saturating bar count, window lengths
  logic [PRICE_W-1:0] high_hist [DEPTH];
  logic [PRICE_W-1:0] low_hist  [DEPTH];
  int unsigned        bars_seen;
  cfg_t               lens_now;

  out_item_t   expected_lines [$];
  int unsigned mismatch_count = 0;
  bit          idle_en = 1'b1;
  int unsigned hold_req = 0;
  logic [PRICE_W-1:0] walk_price = 32'h4000_0000;

  function automatic int unsigned clamp_len(logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > DEPTH) return DEPTH;
    return 32'(len);
  endfunction

  // Highest high plus lowest low over the newest bars, cut to what has been seen
  function automatic logic [TWICE_W-1:0] window_twice(logic [LEN_W-1:0] len);
    int unsigned        span;
    logic [PRICE_W-1:0] hi;
    logic [PRICE_W-1:0] lo;
    span = clamp_len(len);
    if (span > bars_seen) span = bars_seen;
    hi = '0;
    lo = '1;
    for (int unsigned i = 0; i < span; i++) begin
      if (high_hist[i] > hi) hi = high_hist[i];
      if (low_hist[i] < lo) lo = low_hist[i];
    end
    return {1'b0, hi} + {1'b0, lo};
  endfunction

  // Shift one bar into the histories and form the expected cloud lines
  function automatic out_item_t advance_cloud(in_item_t bar);
    out_item_t lines;
    for (int i = DEPTH - 1; i > 0; i--) begin
      high_hist[i] = high_hist[i-1];
      low_hist[i]  = low_hist[i-1];
    end
    high_hist[0] = bar.high_price;
    low_hist[0]  = bar.low_price;
    if (bars_seen < DEPTH) bars_seen++;
    lines.conversion_twice = window_twice(lens_now.conversion_len);
    lines.base_twice       = window_twice(lens_now.base_len);
    lines.span_b_twice     = window_twice(lens_now.span_b_len);
    lines.span_a_quad      = {1'b0, lines.conversion_twice} + {1'b0, lines.base_twice};
    lines.ready_res        = (bars_seen >= clamp_len(lens_now.span_b_len));
    return lines;
  endfunction

  // Mostly a random walk so extremes land at every depth, with extremes and noise mixed in
  function automatic in_item_t make_bar();
    in_item_t    bar;
    int unsigned kind;
    int unsigned spread;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      bar.high_price = $urandom_range(0, 1) ? '1 : '0;
      bar.low_price  = $urandom_range(0, 1) ? '1 : '0;
    end else if (kind <= 2) begin
      bar.high_price = $urandom();
      bar.low_price  = $urandom();
    end else begin
      walk_price     = walk_price + $urandom_range(0, 4000) - 2000;
      spread         = $urandom_range(0, 600);
      bar.high_price = walk_price + spread;
      bar.low_price  = walk_price - spread;
    end
    return bar;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return LEN_W'($urandom_range(65, 127));
      default: return LEN_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Send one bar after a random gap and record its expected lines at the transfer
  task automatic send_bar(input in_item_t bar);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= bar;
    do @(posedge clk_i); while (!in_ready_o);
    expected_lines.push_back(advance_cloud(bar));
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup then access; upper data bits carry noise
  task automatic cfg_write(input logic [1:0] idx, input logic [LEN_W-1:0] len);
    logic [APB_DW-1:0] word;
    word          = $urandom();
    word[LEN_W-1:0] = len;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CONVERSION_LEN: lens_now.conversion_len = len;
      REG_BASE_LEN:       lens_now.base_len       = len;
      REG_SPAN_B_LEN:     lens_now.span_b_len     = len;
      default: ;
    endcase
  endtask

  task automatic set_lens(input logic [LEN_W-1:0] conv, input logic [LEN_W-1:0] base,
                          input logic [LEN_W-1:0] spanb);
    cfg_write(REG_CONVERSION_LEN, conv);
    cfg_write(REG_BASE_LEN, base);
    cfg_write(REG_SPAN_B_LEN, spanb);
  endtask

  task automatic check_field(input string tag, input logic [QUAD_W-1:0] want,
                             input logic [QUAD_W-1:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, tag, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : line_checker
    out_item_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (expected_lines.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = expected_lines.pop_front();
        check_field("conversion_twice", QUAD_W'(want.conversion_twice),
                    QUAD_W'(out_data_o.conversion_twice));
        check_field("base_twice", QUAD_W'(want.base_twice),
                    QUAD_W'(out_data_o.base_twice));
        check_field("span_a_quad", want.span_a_quad, out_data_o.span_a_quad);
        check_field("span_b_twice", QUAD_W'(want.span_b_twice),
                    QUAD_W'(out_data_o.span_b_twice));
        check_field("ready_res", QUAD_W'(want.ready_res),
                    QUAD_W'(out_data_o.ready_res));
      end
    end
  end

  // Result side: random stall after each transfer, or a long hold when requested
  initial begin : result_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = idle_en ? $urandom_range(0, 19) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Warm-up from reset with the default lengths and price extremes
  task automatic test_warmup_defaults();
    send_bar('{high_price: '1, low_price: '0});
    send_bar('{high_price: '0, low_price: '1});
    send_bar('{high_price: 32'h1234_5678, low_price: 32'h1234_0000});
    send_bar('{high_price: '1, low_price: '1});
    send_bar('{high_price: '0, low_price: '0});
    send_bar('{high_price: 32'h8000_0000, low_price: 32'h7FFF_FFFF});
    send_bar('{high_price: 32'h5555_5555, low_price: 32'hAAAA_AAAA});
    send_bar('{high_price: 32'hAAAA_AAAA, low_price: 32'h5555_5555});
    drain();
  endtask

  // Zero, one, full and oversized lengths
  task automatic test_window_edges();
    set_lens('0, 7'd1, 7'd64);
    repeat (6) send_bar(make_bar());
    drain();
    set_lens(7'd64, 7'd127, 7'd65);
    repeat (6) send_bar(make_bar());
    drain();
    cfg_write(REG_SPAN_B_LEN, 7'd1);
    repeat (4) send_bar(make_bar());
    drain();
  endtask

  // Hold the result side so the pipeline fills and the input stalls
  task automatic test_backpressure();
    set_lens(7'd9, 7'd26, 7'd52);
    idle_en  = 1'b0;
    hold_req = 150;
    repeat (40) send_bar(make_bar());
    drain();
    idle_en = 1'b1;
  endtask

  // Random lengths per phase, one phase with no idling on either side
  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      set_lens(pick_len(), pick_len(), pick_len());
      idle_en = (phase != 2);
      repeat (95) send_bar(make_bar());
      drain();
    end
    idle_en = 1'b1;
  endtask

  initial begin : main_seq
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    bars_seen  = 0;
    lens_now   = '{conversion_len: CONVERSION_LEN_RST, base_len: BASE_LEN_RST,
                   span_b_len: SPAN_B_LEN_RST};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_warmup_defaults();
    test_window_edges();
    test_backpressure();
    test_random_phases();

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_lines.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
